[rtl/ppm_hdr_pkg.sv]
// ----------------------------------------------------------------------------
// ppm_hdr_pkg
// Types, codes and character constants shared by the PPM header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_hdr_pkg;

  localparam int DEF_MAX_TOKEN_CHARS = 63;
  localparam int DEF_DIM_BITS        = 16;

  localparam int OUT_DIM_W = 16;
  localparam int MAXVAL_W  = 8;
  localparam int MAXVAL_LIMIT = 255;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_WIDTH  = 3'd2,
    ST_BAD_HEIGHT = 3'd3,
    ST_BAD_MAXVAL = 3'd4,
    ST_EARLY_END  = 3'd5,
    ST_TOO_LONG   = 3'd6,
    ST_EXTRA_TOK  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    TOK_MAGIC  = 2'd0,
    TOK_WIDTH  = 2'd1,
    TOK_HEIGHT = 2'd2,
    TOK_MAXVAL = 2'd3
  } token_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_DIM_W-1:0]   image_width;
    logic [OUT_DIM_W-1:0]   image_height;
    logic [MAXVAL_W-1:0]    max_value;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

[rtl/ppm_hdr_core.sv]
// ----------------------------------------------------------------------------
// ppm_hdr_core
// Parse state of the header: token splitting, comments, magic check and
// decimal accumulation, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_hdr_core #(
  parameter int MAX_TOKEN_CHARS = ppm_hdr_pkg::DEF_MAX_TOKEN_CHARS,
  parameter int DIM_BITS        = ppm_hdr_pkg::DEF_DIM_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire ppm_hdr_pkg::in_item_t item,
  output ppm_hdr_pkg::result_t       res
);
  import ppm_hdr_pkg::*;

  localparam int CC_W  = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int NUM_W = DIM_BITS;
  localparam int ACC_W = DIM_BITS + 4;

  localparam logic [CC_W-1:0]  CC_MAX   = CC_W'(MAX_TOKEN_CHARS);
  localparam logic [CC_W-1:0]  CC_TWO   = CC_W'(2);
  localparam logic [CC_W-1:0]  CC_ONE   = CC_W'(1);
  localparam logic [ACC_W-1:0] DIM_LIM  = ACC_W'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] MAXV_LIM = ACC_W'(MAXVAL_LIMIT);

  token_t           token_number, token_number_next;
  logic             between_tokens, between_tokens_next;
  logic             in_comment, in_comment_next;
  logic [CC_W-1:0]  char_count, char_count_next;
  logic             magic_ok, magic_ok_next;
  logic [NUM_W-1:0] number_value, number_value_next;
  logic             number_bad, number_bad_next;
  logic [NUM_W-1:0] saved_width, saved_width_next;
  logic [NUM_W-1:0] saved_height, saved_height_next;

  logic [7:0]       b;
  logic             is_space;
  logic             is_digit;
  logic             bad_num;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] lim;
  logic             do_char;
  logic             emit;
  status_t          st;

  assign b        = item.data_byte;
  assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign bad_num  = number_bad || (number_value == '0);

  // value*10 + digit; the stored value never exceeds the limit, so this fits
  assign acc = (ACC_W'(number_value) << 3) + (ACC_W'(number_value) << 1)
             + ACC_W'(b - CH_ZERO);
  assign lim = (token_number == TOK_MAXVAL) ? MAXV_LIM : DIM_LIM;

  always_comb begin
    token_number_next   = token_number;
    between_tokens_next = between_tokens;
    in_comment_next     = in_comment;
    char_count_next     = char_count;
    magic_ok_next       = magic_ok;
    number_value_next   = number_value;
    number_bad_next     = number_bad;
    saved_width_next    = saved_width;
    saved_height_next   = saved_height;
    do_char             = 1'b0;
    emit                = 1'b0;
    st                  = ST_OK;

    if (item.end_of_stream) begin
      emit = 1'b1;
      st   = ST_EARLY_END;
    end else if (in_comment) begin
      if ((b == CH_LF) || (b == CH_CR)) begin
        in_comment_next = 1'b0;
      end
    end else if (between_tokens) begin
      if (b == CH_HASH) begin
        in_comment_next = 1'b1;
      end else if (!is_space) begin
        between_tokens_next = 1'b0;
        do_char             = 1'b1;
      end
    end else if (is_space || (b == CH_HASH)) begin
      // close the current token
      unique case (token_number)
        TOK_MAGIC: begin
          if (!magic_ok || (char_count < CC_TWO)) begin
            emit = 1'b1;
            st   = ST_BAD_MAGIC;
          end
        end
        TOK_WIDTH: begin
          if (bad_num) begin
            emit = 1'b1;
            st   = ST_BAD_WIDTH;
          end
          saved_width_next = number_value;
        end
        TOK_HEIGHT: begin
          if (bad_num) begin
            emit = 1'b1;
            st   = ST_BAD_HEIGHT;
          end
          saved_height_next = number_value;
        end
        default: begin
          emit = 1'b1;
          st   = (bad_num || (ACC_W'(number_value) > MAXV_LIM)) ? ST_BAD_MAXVAL : ST_OK;
        end
      endcase
      token_number_next   = token_t'(token_number + 2'd1);
      between_tokens_next = 1'b1;
      char_count_next     = '0;
      number_value_next   = '0;
      number_bad_next     = 1'b0;
      in_comment_next     = (b == CH_HASH);
    end else begin
      do_char = 1'b1;
    end

    if (do_char) begin
      if (char_count >= CC_MAX) begin
        emit = 1'b1;
        st   = ST_TOO_LONG;
      end else begin
        char_count_next = char_count + CC_ONE;
        if (token_number == TOK_MAGIC) begin
          if ((char_count == '0) && (b != CH_P)) begin
            magic_ok_next = 1'b0;
          end
          if ((char_count == CC_ONE) && (b != CH_SIX)) begin
            magic_ok_next = 1'b0;
          end
        end else if (!is_digit) begin
          number_bad_next = 1'b1;
        end else if (!number_bad) begin
          if (acc > lim) begin
            number_bad_next = 1'b1;
          end else begin
            number_value_next = NUM_W'(acc);
          end
        end
      end
    end

    // any result returns the parser to its start state
    if (emit) begin
      token_number_next   = TOK_MAGIC;
      between_tokens_next = 1'b0;
      in_comment_next     = 1'b0;
      char_count_next     = '0;
      magic_ok_next       = 1'b1;
      number_value_next   = '0;
      number_bad_next     = 1'b0;
      saved_width_next    = '0;
      saved_height_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_number   <= TOK_MAGIC;
      between_tokens <= 1'b0;
      in_comment     <= 1'b0;
      char_count     <= '0;
      magic_ok       <= 1'b1;
      number_value   <= '0;
      number_bad     <= 1'b0;
      saved_width    <= '0;
      saved_height   <= '0;
    end else if (step) begin
      token_number   <= token_number_next;
      between_tokens <= between_tokens_next;
      in_comment     <= in_comment_next;
      char_count     <= char_count_next;
      magic_ok       <= magic_ok_next;
      number_value   <= number_value_next;
      number_bad     <= number_bad_next;
      saved_width    <= saved_width_next;
      saved_height   <= saved_height_next;
    end
  end

  always_comb begin
    res.valid             = step && emit;
    res.item.status       = st;
    res.item.image_width  = '0;
    res.item.image_height = '0;
    res.item.max_value    = '0;
    if (st == ST_OK) begin
      res.item.image_width  = OUT_DIM_W'(saved_width);
      res.item.image_height = OUT_DIM_W'(saved_height);
      res.item.max_value    = MAXVAL_W'(number_value);
    end
  end

endmodule

`default_nettype wire

[rtl/ppm_hdr_out_reg.sv]
// ----------------------------------------------------------------------------
// ppm_hdr_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_hdr_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ppm_hdr_pkg::result_t res,
  output logic                      busy,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output ppm_hdr_pkg::out_item_t    result
);
  import ppm_hdr_pkg::*;

  assign busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // hold the payload while stalled; a load only comes when not busy
  always_ff @(posedge clk) begin
    if (res.valid) begin
      result <= res.item;
    end
  end

endmodule

`default_nettype wire

[rtl/ppm_hdr_parser_top_note.sv]
// ----------------------------------------------------------------------------
// ppm_hdr_in_reg
// Input register: captures one header byte and holds it until the parse
// step can consume it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_hdr_in_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire ppm_hdr_pkg::in_item_t item,
  input  wire logic                  busy,
  output logic                       step,
  output ppm_hdr_pkg::in_item_t      held
);
  import ppm_hdr_pkg::*;

  logic held_valid;
  logic accept;

  assign step       = held_valid && !busy;
  assign item_stall = held_valid && busy;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

[rtl/ppm_header_parser.sv]
// ----------------------------------------------------------------------------
// ppm_header_parser
// Binary PPM (P6) header parser: one header byte per transfer in, one
// status/width/height/maxval result out per header or error.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while the result side does not stall,
// and emits a result for the byte that finishes the header or reveals an error.
// Each byte passes an input register, then one parse step that updates the
// token state (a compare, and a multiply-by-ten add for number digits), and
// the result lands in an output register. A stall on the result side holds
// the input side after one buffered byte. After each result the parser is
// back in its start state and parses the following bytes as a new header.
`default_nettype none

module ppm_header_parser #(
  parameter int MAX_TOKEN_CHARS = ppm_hdr_pkg::DEF_MAX_TOKEN_CHARS,
  parameter int DIM_BITS        = ppm_hdr_pkg::DEF_DIM_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire ppm_hdr_pkg::in_item_t  item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output ppm_hdr_pkg::out_item_t      result
);
  import ppm_hdr_pkg::*;

  logic     busy;
  logic     step;
  in_item_t held;
  result_t  res;

  ppm_hdr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .busy       (busy),
    .step       (step),
    .held       (held)
  );

  ppm_hdr_core #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .DIM_BITS        (DIM_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held),
    .res  (res)
  );

  ppm_hdr_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[test/ppm_header_parser_tb.sv]
// ----------------------------------------------------------------------------
// ppm_header_parser_tb
// Self-checking bench for the P6 header parser. A behavioral parser follows
// each accepted byte and queues the result it implies. The results from the
// block are checked field by field, in order. Stimulus is directed corner
// cases, random byte noise, and random headers with injected faults, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppm_hdr_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef enum int {
    HF_NONE, HF_BAD_MAGIC, HF_ZERO, HF_OVERFLOW, HF_NON_DIGIT,
    HF_TOO_LONG, HF_EARLY_END, HF_NOISE
  } hdr_fault_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  ppm_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser state mirrored by the bench
  token_t               tok_idx;
  bit                   tok_gap;
  bit                   in_cmt;
  bit                   magic_good;
  bit                   num_bad;
  int unsigned          tok_chars;
  longint unsigned      num_val;
  logic [OUT_DIM_W-1:0] w_hold;
  logic [OUT_DIM_W-1:0] h_hold;

  out_item_t predicted_headers[$];
  in_item_t  byte_stream[$];

  bit idle_on = 1'b0;
  int sent_items = 0;
  int live_items = 0;
  int eos_items = 0;
  int checked = 0;
  int bad_count = 0;
  int status_seen[8];
  int stall_cnt = 0;
  int quiet_cycles = 0;

  function automatic void parser_clear();
    tok_idx    = TOK_MAGIC;
    tok_gap    = 1'b0;
    in_cmt     = 1'b0;
    tok_chars  = 0;
    magic_good = 1'b1;
    num_val    = 0;
    num_bad    = 1'b0;
    w_hold     = '0;
    h_hold     = '0;
  endfunction

  function automatic void push_header(status_t st, logic [OUT_DIM_W-1:0] w,
                                      logic [OUT_DIM_W-1:0] h,
                                      logic [MAXVAL_W-1:0] m);
    out_item_t r;
    r.status       = st;
    r.image_width  = w;
    r.image_height = h;
    r.max_value    = m;
    predicted_headers.push_back(r);
    parser_clear();
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void take_char(logic [7:0] b);
    longint unsigned lim;
    longint unsigned d;
    if (tok_idx == TOK_MAGIC) begin
      if (tok_chars == 0 && b != CH_P) magic_good = 1'b0;
      if (tok_chars == 1 && b != CH_SIX) magic_good = 1'b0;
      return;
    end
    if (b < CH_ZERO || b > CH_NINE) begin
      num_bad = 1'b1;
      return;
    end
    if (!num_bad) begin
      lim = (tok_idx == TOK_MAXVAL) ? MAXVAL_LIMIT : (64'd1 << DEF_DIM_BITS) - 1;
      d   = b - CH_ZERO;
      if (num_val > (lim - d) / 10) num_bad = 1'b1;
      else num_val = num_val * 10 + d;
    end
  endfunction

  // Returns 1 when the closed token ends the header with a result.
  function automatic bit close_token();
    bit bad;
    bad = num_bad || num_val == 0;
    case (tok_idx)
      TOK_MAGIC: begin
        if (!magic_good || tok_chars < 2) begin
          push_header(ST_BAD_MAGIC, '0, '0, '0);
          return 1'b1;
        end
      end
      TOK_WIDTH: begin
        if (bad) begin
          push_header(ST_BAD_WIDTH, '0, '0, '0);
          return 1'b1;
        end
        w_hold = OUT_DIM_W'(num_val);
      end
      TOK_HEIGHT: begin
        if (bad) begin
          push_header(ST_BAD_HEIGHT, '0, '0, '0);
          return 1'b1;
        end
        h_hold = OUT_DIM_W'(num_val);
      end
      default: begin
        if (bad || num_val > MAXVAL_LIMIT) push_header(ST_BAD_MAXVAL, '0, '0, '0);
        else push_header(ST_OK, w_hold, h_hold, MAXVAL_W'(num_val));
        return 1'b1;
      end
    endcase
    tok_idx   = token_t'(tok_idx + 2'd1);
    tok_gap   = 1'b1;
    tok_chars = 0;
    num_val   = 0;
    num_bad   = 1'b0;
    return 1'b0;
  endfunction

  // Advance the mirrored parser by one transfer; returns 1 if it was skipped
  // as comment text or blank space between tokens.
  function automatic bit parse_header_byte(in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (it.end_of_stream) begin
      push_header(ST_EARLY_END, '0, '0, '0);
      return 1'b0;
    end
    if (in_cmt) begin
      if (b == CH_LF || b == CH_CR) in_cmt = 1'b0;
      return 1'b1;
    end
    if (tok_gap) begin
      if (is_blank(b)) return 1'b1;
      if (b == CH_HASH) begin
        in_cmt = 1'b1;
        return 1'b1;
      end
      tok_gap = 1'b0;
    end else begin
      if (is_blank(b)) begin
        void'(close_token());
        return 1'b0;
      end
      if (b == CH_HASH) begin
        if (!close_token()) in_cmt = 1'b1;
        return 1'b0;
      end
    end
    if (tok_chars >= DEF_MAX_TOKEN_CHARS) begin
      push_header(ST_TOO_LONG, '0, '0, '0);
      return 1'b0;
    end
    take_char(b);
    tok_chars++;
    return 1'b0;
  endfunction

  // Stimulus building
  function automatic void put_byte(logic [7:0] b);
    byte_stream.push_back('{data_byte: b, end_of_stream: 1'b0});
  endfunction

  function automatic void put_eos();
    byte_stream.push_back('{data_byte: 8'($urandom_range(0, 255)), end_of_stream: 1'b1});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_token_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b) || b == CH_HASH);
    return b;
  endfunction

  function automatic void put_sep();
    int parts;
    logic [7:0] c;
    parts = $urandom_range(1, 3);
    for (int p = 0; p < parts; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
          put_byte(c);
        end
        put_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(pick_blank());
      end
    end
  endfunction

  // One header, mostly well formed, with at most one fault in one token.
  function automatic void build_header();
    hdr_fault_t fault;
    hdr_fault_t f;
    int tgt;
    int len;
    int pos;
    int cut;
    longint unsigned lim;
    longint unsigned v;
    string s;
    logic [7:0] c;

    fault = HF_NONE;
    if ($urandom_range(0, 99) < 40) fault = hdr_fault_t'($urandom_range(1, HF_NOISE));
    case (fault)
      HF_BAD_MAGIC: tgt = 0;
      HF_TOO_LONG:  tgt = $urandom_range(0, 3);
      default:      tgt = $urandom_range(1, 3);
    endcase

    f = (tgt == 0) ? fault : HF_NONE;
    if (f == HF_BAD_MAGIC) begin
      case ($urandom_range(0, 5))
        0: put_text("P5");
        1: put_text("p6");
        2: put_text("P");
        3: put_text("6P");
        4: ;  // empty magic: the separator below ends it at once
        default: begin
          put_byte(rand_token_char());
          put_byte(rand_token_char());
        end
      endcase
    end else begin
      put_text("P6");
      len = (f == HF_TOO_LONG) ? $urandom_range(60, 64) : $urandom_range(0, 2);
      repeat (len) put_byte(rand_token_char());
    end

    for (int k = 1; k <= 3; k++) begin
      put_sep();
      f   = (tgt == k) ? fault : HF_NONE;
      lim = (k == 3) ? MAXVAL_LIMIT : (64'd1 << DEF_DIM_BITS) - 1;
      case ($urandom_range(0, 5))
        0: v = 1;
        1: v = lim;
        2: v = $urandom_range(1, 9);
        default: v = $urandom_range(1, int'(lim));
      endcase
      case (f)
        HF_ZERO: repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
        HF_OVERFLOW: begin
          v = lim + 1;
          if ($urandom_range(0, 1)) v = v + $urandom_range(0, 99999);
          put_text($sformatf("%0d", v));
        end
        HF_NON_DIGIT: begin
          s   = $sformatf("%0d", v);
          pos = $urandom_range(0, s.len());
          for (int i = 0; i <= s.len(); i++) begin
            if (i == pos) begin
              do c = rand_token_char(); while (c >= CH_ZERO && c <= CH_NINE);
              put_byte(c);
            end
            if (i < s.len()) put_byte(s[i]);
          end
        end
        HF_TOO_LONG: begin
          // straddle the length limit: 62 to 66 characters
          repeat ($urandom_range(61, 65)) put_byte(CH_ZERO);
          put_byte(CH_ZERO + 8'($urandom_range(1, 9)));
        end
        default: begin
          if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
          put_text($sformatf("%0d", v));
        end
      endcase
    end

    if ($urandom_range(0, 4) == 0) put_byte(CH_HASH);
    else put_byte(pick_blank());

    if (fault == HF_EARLY_END) begin
      cut = $urandom_range(0, byte_stream.size() - 1);
      while (byte_stream.size() > cut) void'(byte_stream.pop_back());
      put_eos();
    end else if (fault == HF_NOISE) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // One transfer on the input side, with an optional gap before it.
  task automatic send_item(in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sent_items++;
    if (it.end_of_stream) eos_items++;
    if (!parse_header_byte(it)) live_items++;
  endtask

  task automatic send_stream();
    while (byte_stream.size() != 0) send_item(byte_stream.pop_front());
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b0;
    put_eos();                // end mark before any byte
    put_byte(CH_SPACE);       // leading blank: empty magic
    put_byte(CH_HASH);        // leading comment: empty magic
    put_text("P6");
    put_byte(8'hFF);
    put_byte(CH_HASH);        // comment closes the magic token
    put_byte(CH_LF);
    put_text("65535");
    put_byte(CH_TAB);
    put_text("1");
    put_byte(CH_HASH);
    put_byte(CH_CR);
    put_text("255");
    put_byte(CH_VT);
    put_text("P5");
    put_byte(8'h00);
    put_byte(CH_FF);
    send_stream();
  endtask

  task automatic test_byte_noise(int goal);
    int stop;
    stop    = sent_items + goal;
    idle_on = 1'b1;
    while (sent_items < stop) begin
      if ($urandom_range(0, 15) == 0) put_eos();
      else put_byte(8'($urandom_range(0, 255)));
      send_item(byte_stream.pop_front());
    end
  endtask

  task automatic test_random_headers(int goal);
    int stop;
    stop = sent_items + goal;
    while (sent_items < stop) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_header();
      send_stream();
    end
  endtask

  task automatic test_full_rate(int goal);
    int stop;
    stop    = sent_items + goal;
    idle_on = 1'b0;
    while (sent_items < stop) begin
      build_header();
      send_stream();
    end
  endtask

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt    <= stall_cnt - 1;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt    <= $urandom_range(0, 7);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      checked++;
      if (predicted_headers.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: status=%0d width=%0d height=%0d maxval=%0d",
                   result.status, result.image_width, result.image_height,
                   result.max_value);
      end else begin
        want = predicted_headers.pop_front();
        status_seen[want.status]++;
        if (result.status !== want.status || result.image_width !== want.image_width ||
            result.image_height !== want.image_height ||
            result.max_value !== want.max_value) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result %0d mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     checked, want.status, want.image_width, want.image_height,
                     want.max_value, result.status, result.image_width,
                     result.image_height, result.max_value);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL ppm_header_parser");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    parser_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_byte_noise(150);
    test_random_headers(1250);
    test_full_rate(200);

    item_valid <= 1'b0;
    while (predicted_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transfers (%0d parsed, %0d end marks), checked %0d results.",
             sent_items, live_items, eos_items, checked);
    $display("By status: ok %0d, magic %0d, width %0d, height %0d, maxval %0d, %s %0d, %s %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_MAGIC], status_seen[ST_BAD_WIDTH],
             status_seen[ST_BAD_HEIGHT], status_seen[ST_BAD_MAXVAL], "early end",
             status_seen[ST_EARLY_END], "too long", status_seen[ST_TOO_LONG]);
    if (bad_count == 0 && predicted_headers.size() == 0)
      $display("PASS ppm_header_parser");
    else
      $display("FAIL ppm_header_parser");
    $finish;
  end

endmodule

`default_nettype wire
